// ===== hw/rtl/st_pkg.sv =====
package st_pkg;

  localparam int LEN_W = 8;
  localparam int KW_N = 8;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = 2;
  localparam int CNT_W = 3;

  localparam logic [2:0] KIND_INT     = 3'd0;
  localparam logic [2:0] KIND_FLOAT   = 3'd1;
  localparam logic [2:0] KIND_KEYWORD = 3'd2;
  localparam logic [2:0] KIND_IDENT   = 3'd3;
  localparam logic [2:0] KIND_OPER    = 3'd4;
  localparam logic [2:0] KIND_PUNCT   = 3'd5;
  localparam logic [2:0] KIND_INVALID = 3'd6;
  localparam logic [2:0] KIND_END     = 3'd7;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] KW_TEXT [0:KW_N-1][0:7] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
    '{"s", "t", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "t", "r", "i", "n", "g", 8'h00, 8'h00},
    '{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"F", "i", "l", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "t", "a", "t", "i", "c", 8'h00, 8'h00},
    '{"m", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [0:KW_N-1] = '{
    3'd3, 3'd5, 3'd3, 3'd6, 3'd4, 3'd4, 3'd6, 3'd3
  };

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_NUM   = 4'b0010,
    MODE_IDENT = 4'b0100,
    MODE_SYM   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [6:0] token_length;
    logic [7:0] first_byte;
    logic       length_overflow;
    logic       last;
  } out_item_t;

endpackage

// ===== hw/rtl/source_tokenizer.sv =====
// Streaming source tokenizer.
// Input channel (in_valid/in_ready/in_data): one source byte or an end
// marker per transfer. Output channel (out_valid/out_ready/out_data): one
// token per transfer with kind, length, first byte, overflow flag, and last
// set on the final token caused by an input transfer.
// Each input transfer is classified in the cycle it is accepted; the zero,
// one or two tokens it finishes are written into a four-entry result queue
// and reach out_data when they come to the head of that queue.
// One input transfer is taken every cycle while the queue has two free
// entries; sustained rate is one byte per cycle as long as tokens leave at
// one per cycle. An input that finishes two tokens (a pending token and a
// one-byte symbol or invalid byte, or a pending token and end) occupies two queue entries.
// When the receiver stalls, the queue fills and in_ready drops until
// entries are taken; nothing is lost or repeated.
// Reset empties the queue and returns the scanner to idle with no pending
// token.
module source_tokenizer #(
  parameter int MAX_TOKEN_LEN = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  st_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output st_pkg::out_item_t out_data
);

  import st_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN_LEN);

  mode_t            mode, mode_next;
  logic [7:0]       first, first_next;
  logic [LEN_W-1:0] len, len_next;
  logic             point, point_next;
  logic [KW_N-1:0]  hits, hits_next;
  logic             too_long, too_long_next;

  out_item_t        fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] rd_ptr, wr_ptr;
  logic [CNT_W-1:0] fill;

  logic [7:0]       c;
  logic             c_digit, c_alpha, c_word, c_space, c_sym_pend, c_oper1, c_punct1;
  logic [LEN_W-1:0] ext_len;
  logic             ext_long;
  logic [KW_N-1:0]  hits_upd, hits_init;
  logic             is_kw;
  logic             pair_oper, pair_punct;
  logic             restart;
  logic             accept, pop;

  mode_t            st_mode;
  logic             st_vld;
  out_item_t        st_res, flush_res, a_res, b_res, slot0, slot1;
  logic             a_vld, b_vld;
  logic [1:0]       n_res;

  assign c = in_data.data_byte;
  assign c_digit = (c >= "0") && (c <= "9");
  assign c_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign c_word = c_alpha || c_digit || (c == "_");
  assign c_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  assign c_sym_pend = (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "=")
                   || (c == ">") || (c == "!") || (c == "&") || (c == "|") || (c == "^")
                   || (c == "]") || (c == "<");
  assign c_oper1 = (c == "~") || (c == "%");
  assign c_punct1 = (c == ",") || (c == ".") || (c == ":") || (c == "(") || (c == ")")
                 || (c == "[") || (c == "{") || (c == "}");

  assign ext_len = (len >= MAX_LEN) ? len : len + 1'b1;
  assign ext_long = too_long || (len >= MAX_LEN);

  always_comb begin
    is_kw = 1'b0;
    for (int i = 0; i < KW_N; i++) begin
      hits_upd[i] = hits[i] && (len < LEN_W'(KW_LEN[i])) && (KW_TEXT[i][len[2:0]] == c);
      hits_init[i] = (KW_TEXT[i][0] == c);
      if (hits[i] && (LEN_W'(KW_LEN[i]) == len)) begin
        is_kw = 1'b1;
      end
    end
  end

  assign pair_oper = (((first == "+") || (first == "-") || (first == "*") || (first == "/")
                    || (first == "=") || (first == ">") || (first == "!") || (first == "<"))
                    && (c == "="))
                  || (((first == "&") || (first == "|") || (first == "^")) && (c == first));
  assign pair_punct = ((first == "<") && (c == "[")) || ((first == "]") && (c == ">"));

  always_comb begin
    flush_res = '0;
    flush_res.first_byte = first;
    flush_res.token_length = len[6:0];
    flush_res.length_overflow = too_long;
    unique case (mode)
      MODE_NUM: begin
        flush_res.token_kind = point ? KIND_FLOAT : KIND_INT;
      end
      MODE_IDENT: begin
        flush_res.token_kind = (is_kw && !too_long) ? KIND_KEYWORD : KIND_IDENT;
      end
      MODE_SYM: begin
        flush_res.token_length = 7'd1;
        flush_res.length_overflow = 1'b0;
        if (first == "]") begin
          flush_res.token_kind = KIND_PUNCT;
        end else if ((first == "&") || (first == "|")) begin
          flush_res.token_kind = KIND_INVALID;
        end else begin
          flush_res.token_kind = KIND_OPER;
        end
      end
      default: begin
        flush_res.token_kind = KIND_END;
      end
    endcase
  end

  always_comb begin
    st_vld = 1'b0;
    st_mode = MODE_IDLE;
    st_res = '0;
    st_res.token_length = 7'd1;
    st_res.first_byte = c;
    priority if (c_space) begin
      st_mode = MODE_IDLE;
    end else if (c_digit) begin
      st_mode = MODE_NUM;
    end else if (c_alpha || (c == "_")) begin
      st_mode = MODE_IDENT;
    end else if (c_sym_pend) begin
      st_mode = MODE_SYM;
    end else if (c_oper1) begin
      st_vld = 1'b1;
      st_res.token_kind = KIND_OPER;
    end else if (c_punct1) begin
      st_vld = 1'b1;
      st_res.token_kind = KIND_PUNCT;
    end else begin
      st_vld = 1'b1;
      st_res.token_kind = KIND_INVALID;
    end
  end

  always_comb begin
    mode_next = mode;
    first_next = first;
    len_next = len;
    point_next = point;
    hits_next = hits;
    too_long_next = too_long;
    a_vld = 1'b0;
    a_res = flush_res;
    b_vld = 1'b0;
    b_res = '0;
    restart = 1'b0;
    if (in_data.operation == OP_END) begin
      a_vld = (mode != MODE_IDLE);
      b_vld = 1'b1;
      b_res.token_kind = KIND_END;
      mode_next = MODE_IDLE;
    end else begin
      unique case (mode)
        MODE_NUM: begin
          if (c_digit) begin
            len_next = ext_len;
            too_long_next = ext_long;
          end else if ((c == ".") && !point) begin
            point_next = 1'b1;
            len_next = ext_len;
            too_long_next = ext_long;
          end else if (c == ".") begin
            len_next = ext_len;
            too_long_next = ext_long;
            a_vld = 1'b1;
            a_res.token_kind = KIND_INVALID;
            a_res.token_length = ext_len[6:0];
            a_res.length_overflow = ext_long;
            mode_next = MODE_IDLE;
          end else begin
            restart = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (c_word) begin
            hits_next = hits_upd;
            len_next = ext_len;
            too_long_next = ext_long;
          end else begin
            restart = 1'b1;
          end
        end
        MODE_SYM: begin
          if (pair_oper || pair_punct) begin
            a_vld = 1'b1;
            a_res.token_kind = pair_oper ? KIND_OPER : KIND_PUNCT;
            a_res.token_length = 7'd2;
            a_res.length_overflow = 1'b0;
            mode_next = MODE_IDLE;
          end else begin
            restart = 1'b1;
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase
    end
    if (restart) begin
      a_vld = (mode != MODE_IDLE);
      mode_next = st_mode;
      b_vld = st_vld;
      b_res = st_res;
      if (!c_space) begin
        first_next = c;
        len_next = LEN_W'(1);
        too_long_next = 1'b0;
        point_next = 1'b0;
        hits_next = (c_alpha || (c == "_")) ? hits_init : '0;
      end
    end
  end

  always_comb begin
    slot0 = a_vld ? a_res : b_res;
    slot0.last = !(a_vld && b_vld);
    slot1 = b_res;
    slot1.last = 1'b1;
    n_res = {1'b0, a_vld} + {1'b0, b_vld};
  end

  assign in_ready = (fill <= CNT_W'(FIFO_DEPTH - 2));
  assign accept = in_valid && in_ready;
  assign out_valid = (fill != '0);
  assign out_data = fifo[rd_ptr];
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      first <= '0;
      len <= '0;
      point <= 1'b0;
      hits <= '0;
      too_long <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      first <= first_next;
      len <= len_next;
      point <= point_next;
      hits <= hits_next;
      too_long <= too_long_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (n_res != 2'd0)) begin
      fifo[wr_ptr] <= slot0;
    end
    if (accept && (n_res == 2'd2)) begin
      fifo[wr_ptr + 1'b1] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + PTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (accept ? CNT_W'(n_res) : '0) - CNT_W'(pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overrun");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.operation == OP_END) |=> (mode == MODE_IDLE) && out_valid)
    else $error("end of input left a pending token or no result");

  a_end_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.token_kind == KIND_END)
      |-> out_data.last && (out_data.token_length == 7'd0) && !out_data.length_overflow)
    else $error("malformed end token");

endmodule

// ===== bench/source_tokenizer_test.sv =====
module source_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import st_pkg::*;

  localparam int MAX_TOKEN_LEN = 64;
  localparam int RANDOM_ITEMS = 550;
  localparam int CALM_ITEMS = 80;
  localparam int QUIET_LIMIT = 2000;

  class token_scoreboard;
    out_item_t expected_tokens[$];
    out_item_t batch[$];
    int errors;
    string keywords[8];
    mode_t scan_state;
    logic [7:0] lead;
    int length;
    bit point;
    logic [7:0] hits;
    bit overlong;

    function new();
      keywords = '{"int", "float", "str", "String", "bool", "File", "static", "mut"};
      scan_state = MODE_IDLE;
      lead = '0;
      length = 0;
      point = 0;
      hits = '0;
      overlong = 0;
      errors = 0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_word(logic [7:0] c);
      return is_letter(c) || is_digit(c) || c == "_";
    endfunction

    function void emit_token(logic [2:0] kind, int len, logic [7:0] first, bit ovf);
      out_item_t t;
      t.token_kind = kind;
      t.token_length = 7'(len);
      t.first_byte = first;
      t.length_overflow = ovf;
      t.last = 1'b0;
      batch.push_back(t);
    endfunction

    function void grow();
      if (length >= MAX_TOKEN_LEN) overlong = 1;
      else length++;
    endfunction

    function void match_keywords(logic [7:0] c);
      string w;
      for (int i = 0; i < 8; i++) begin
        if (hits[i]) begin
          w = keywords[i];
          if (length >= w.len() || w[length] != c) hits[i] = 1'b0;
        end
      end
    endfunction

    function void flush_pending();
      logic [2:0] kind;
      case (scan_state)
        MODE_NUM: begin
          emit_token(point ? KIND_FLOAT : KIND_INT, length, lead, overlong);
        end
        MODE_IDENT: begin
          kind = KIND_IDENT;
          if (!overlong)
            for (int i = 0; i < 8; i++)
              if (hits[i] && keywords[i].len() == length) kind = KIND_KEYWORD;
          emit_token(kind, length, lead, overlong);
        end
        MODE_SYM: begin
          if (lead == "]") kind = KIND_PUNCT;
          else if (lead == "&" || lead == "|") kind = KIND_INVALID;
          else kind = KIND_OPER;
          emit_token(kind, 1, lead, 1'b0);
        end
        default: ;
      endcase
      scan_state = MODE_IDLE;
    endfunction

    function void begin_token(logic [7:0] c);
      scan_state = MODE_IDLE;
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
      lead = c;
      length = 1;
      overlong = 0;
      point = 0;
      hits = '0;
      if (is_digit(c)) begin
        scan_state = MODE_NUM;
      end else if (is_letter(c) || c == "_") begin
        hits = 8'hFF;
        length = 0;
        match_keywords(c);
        length = 1;
        scan_state = MODE_IDENT;
      end else if (c inside {"+", "-", "*", "/", "=", ">", "!", "&", "|", "^", "]", "<"}) begin
        scan_state = MODE_SYM;
      end else if (c == "~" || c == "%") begin
        emit_token(KIND_OPER, 1, c, 1'b0);
      end else if (c inside {",", ".", ":", "(", ")", "[", "{", "}"}) begin
        emit_token(KIND_PUNCT, 1, c, 1'b0);
      end else begin
        emit_token(KIND_INVALID, 1, c, 1'b0);
      end
    endfunction

    function void note_source(in_item_t item);
      logic [7:0] c;
      logic [7:0] f;
      logic [2:0] pair_kind;
      bit paired;
      out_item_t t;
      batch.delete();
      c = item.data_byte;
      f = lead;
      paired = 0;
      pair_kind = KIND_OPER;
      if (item.operation == OP_END) begin
        flush_pending();
        emit_token(KIND_END, 0, 8'h00, 1'b0);
      end else begin
        case (scan_state)
          MODE_NUM: begin
            if (is_digit(c)) begin
              grow();
            end else if (c == "." && !point) begin
              point = 1;
              grow();
            end else if (c == ".") begin
              grow();
              emit_token(KIND_INVALID, length, lead, overlong);
              scan_state = MODE_IDLE;
            end else begin
              flush_pending();
              begin_token(c);
            end
          end
          MODE_IDENT: begin
            if (is_word(c)) begin
              match_keywords(c);
              grow();
            end else begin
              flush_pending();
              begin_token(c);
            end
          end
          MODE_SYM: begin
            if (f inside {"+", "-", "*", "/", "=", ">", "!"} && c == "=") begin
              paired = 1;
            end else if (f inside {"&", "|", "^"} && c == f) begin
              paired = 1;
            end else if (f == "<" && c == "=") begin
              paired = 1;
            end else if (f == "<" && c == "[") begin
              paired = 1;
              pair_kind = KIND_PUNCT;
            end else if (f == "]" && c == ">") begin
              paired = 1;
              pair_kind = KIND_PUNCT;
            end
            if (paired) begin
              emit_token(pair_kind, 2, f, 1'b0);
              scan_state = MODE_IDLE;
            end else begin
              flush_pending();
              begin_token(c);
            end
          end
          default: begin
            begin_token(c);
          end
        endcase
      end
      foreach (batch[i]) begin
        t = batch[i];
        t.last = (i == batch.size() - 1);
        expected_tokens.push_back(t);
      end
    endfunction

    function void check_token(out_item_t got);
      out_item_t want;
      if (expected_tokens.size() == 0) begin
        $error("token with none expected: kind %0d length %0d first %02h",
               got.token_kind, got.token_length, got.first_byte);
        errors++;
        return;
      end
      want = expected_tokens.pop_front();
      if (got.token_kind !== want.token_kind) begin
        $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
        errors++;
      end
      if (got.token_length !== want.token_length) begin
        $error("token_length: expected %0d, got %0d", want.token_length, got.token_length);
        errors++;
      end
      if (got.first_byte !== want.first_byte) begin
        $error("first_byte: expected %02h, got %02h", want.first_byte, got.first_byte);
        errors++;
      end
      if (got.length_overflow !== want.length_overflow) begin
        $error("length_overflow: expected %0d, got %0d",
               want.length_overflow, got.length_overflow);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  token_scoreboard board = new();
  bit sender_idles = 1;
  bit receiver_stalls = 1;
  int sent = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  source_tokenizer #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) board.note_source(in_data);
    if (!rst && out_valid && out_ready) board.check_token(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("source_tokenizer_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0 && receiver_stalls && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 6);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    in_item_t item;
    item.operation = op;
    item.data_byte = b;
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.expected_tokens.size() != 0);
  endtask

  function automatic logic [7:0] random_word_char(bit leading);
    int r;
    r = leading ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] random_space();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? 8'h20 : 8'(r);
  endfunction

  task automatic send_random_token();
    string symbols;
    string partners;
    int pick;
    int n;
    logic [7:0] c;
    symbols = "+-*/%^>=<!~&|,.:()[]{}";
    partners = "=&|^[>";
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_text(board.keywords[$urandom_range(0, 7)]);
      if ($urandom_range(0, 3) == 0) send_item(OP_BYTE, random_word_char(0));
    end else if (pick < 30) begin
      send_item(OP_BYTE, random_word_char(1));
      repeat ($urandom_range(0, 8)) send_item(OP_BYTE, random_word_char(0));
    end else if (pick < 48) begin
      repeat ($urandom_range(1, 5)) send_item(OP_BYTE, 8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 1) == 0) begin
        send_item(OP_BYTE, ".");
        repeat ($urandom_range(0, 4)) send_item(OP_BYTE, 8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 5) == 0) send_item(OP_BYTE, ".");
      end
    end else if (pick < 70) begin
      c = symbols[$urandom_range(0, symbols.len() - 1)];
      send_item(OP_BYTE, c);
      n = $urandom_range(0, 3);
      if (n == 1) send_item(OP_BYTE, c);
      else if (n > 1) send_item(OP_BYTE, partners[$urandom_range(0, partners.len() - 1)]);
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 3)) send_item(OP_BYTE, random_space());
    end else if (pick < 91) begin
      send_item(OP_BYTE, 8'($urandom_range(0, 255)));
    end else if (pick < 98) begin
      send_item(OP_END, 8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(62, 70);
      if ($urandom_range(0, 1) == 0) begin
        send_item(OP_BYTE, random_word_char(1));
        repeat (n - 1) send_item(OP_BYTE, random_word_char(0));
      end else begin
        repeat (n) send_item(OP_BYTE, 8'("0" + $urandom_range(0, 9)));
      end
    end
    if ($urandom_range(0, 1) == 0) send_item(OP_BYTE, random_space());
  endtask

  initial begin
    bit paused;
    paused = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_text("12.3.&x<[]>< ");
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_text("int");
    send_item(OP_END, 8'hFF);
    send_text("^^~");
    send_item(OP_END, 8'h00);
    wait_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) begin
        sender_idles = 0;
        receiver_stalls = 0;
      end else if ($urandom_range(0, 29) == 0) begin
        sender_idles = $urandom_range(0, 1);
        receiver_stalls = $urandom_range(0, 1);
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1;
      end
      send_random_token();
    end
    send_item(OP_END, 8'($urandom_range(0, 255)));

    wait_drained();
    repeat (8) @(posedge clk);
    if (board.errors == 0) $display("source_tokenizer_test: PASS");
    else $display("source_tokenizer_test: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/st_pkg.sv
hw/rtl/source_tokenizer.sv
bench/source_tokenizer_test.sv
